FILE: rtl/core/pcapp_pkg.sv
// pcapp_pkg: shared types and constants of the pcap stream parser.
// No dependencies; used by every module of the block.
`default_nettype none
package pcapp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [31:0] MAX_CAP_RESET = 32'd262144;
  localparam logic [31:0] NS_PER_S = 32'd1000000000;
  localparam logic [31:0] US_PER_S = 32'd1000000;
  localparam logic [9:0]  NS_PER_US = 10'd1000;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_END     = 2'd3
  } kind_e;

  localparam logic [3:0] ERR_TRUNC_GLOBAL = 4'd0;
  localparam logic [3:0] ERR_MAGIC        = 4'd1;
  localparam logic [3:0] ERR_VERSION      = 4'd2;
  localparam logic [3:0] ERR_SNAPLEN      = 4'd3;
  localparam logic [3:0] ERR_TRUNC_REC    = 4'd4;
  localparam logic [3:0] ERR_FRACTION     = 4'd5;
  localparam logic [3:0] ERR_OVERFLOW     = 4'd6;
  localparam logic [3:0] ERR_OVER_SNAP    = 4'd7;
  localparam logic [3:0] ERR_OVER_LIMIT   = 4'd8;
  localparam logic [3:0] ERR_ORIG_SHORT   = 4'd9;
  localparam logic [3:0] ERR_TRUNC_DATA   = 4'd10;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] secs;
    logic [31:0] frac;
    logic [31:0] cap;
    logic [31:0] orig;
    logic [63:0] offset;
    logic [7:0]  data;
    logic        last;
    logic [3:0]  code;
  } q_item_t;

  typedef struct packed {
    logic        nano;
    logic [31:0] snap;
    logic [31:0] link;
  } hdr_info_t;

endpackage
`default_nettype wire

FILE: rtl/core/pcapp_fifo.sv
// pcapp_fifo: short request queue between front and back.
// Depends on pcapp_pkg for the item type.
`default_nettype none
module pcapp_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  pcapp_pkg::q_item_t  push_data_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                nonempty_o,
  output pcapp_pkg::q_item_t  head_o
);
  import pcapp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/pcapp_front.sv
// pcapp_front: byte intake, header collection and request classification.
// Depends on pcapp_pkg; feeds pcapp_fifo.
`default_nettype none
module pcapp_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [7:0]          data_byte_i,
  input  wire                 end_of_input_i,
  input  wire                 full_i,
  output logic                push_o,
  output pcapp_pkg::q_item_t  push_data_o,
  output pcapp_pkg::hdr_info_t info_o
);
  import pcapp_pkg::*;

  typedef enum logic [1:0] {
    PH_GLOBAL, PH_RECORD, PH_PAYLOAD, PH_HALTED
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  bc_q, bc_d;
  logic [7:0]  hdr_q [24];
  logic [7:0]  hv [24];
  logic        le_q, le_d, nano_q, nano_d;
  logic [31:0] snap_q, snap_d, link_q, link_d, rem_q, rem_d;
  logic [63:0] pos_q, pos_d;
  logic        acc;
  logic        write_hdr;
  q_item_t     item;

  function automatic logic [31:0] word32(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic le);
    return le ? {b3, b2, b1, b0} : {b0, b1, b2, b3};
  endfunction

  assign in_ready_o = (phase_q == PH_HALTED) || !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign info_o     = '{nano: nano_q, snap: snap_q, link: link_q};

  always_comb begin
    for (int i = 0; i < 24; i++) begin
      hv[i] = (bc_q == 5'(i)) ? data_byte_i : hdr_q[i];
    end
  end

  always_comb begin
    logic [15:0] v4, v6;
    logic [31:0] snapw;
    logic        lem, nanom, okm;
    phase_d   = phase_q;
    bc_d      = bc_q;
    le_d      = le_q;
    nano_d    = nano_q;
    snap_d    = snap_q;
    link_d    = link_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    push_o    = 1'b0;
    write_hdr = 1'b0;
    item      = '0;
    v4 = '0; v6 = '0; snapw = '0; lem = 1'b0; nanom = 1'b0; okm = 1'b1;
    if (acc && phase_q != PH_HALTED) begin
      if (end_of_input_i) begin
        push_o    = 1'b1;
        item.kind = KIND_ERROR;
        phase_d   = PH_HALTED;
        unique case (phase_q)
          PH_GLOBAL:  item.code = ERR_TRUNC_GLOBAL;
          PH_PAYLOAD: item.code = ERR_TRUNC_DATA;
          default: begin
            if (bc_q != '0) item.code = ERR_TRUNC_REC;
            else            item.kind = KIND_END;
          end
        endcase
      end else begin
        pos_d = pos_q + 64'd1;
        if (phase_q == PH_PAYLOAD) begin
          push_o    = 1'b1;
          item.kind = KIND_PAYLOAD;
          item.data = data_byte_i;
          item.last = (rem_q == 32'd1);
          rem_d     = rem_q - 32'd1;
          if (rem_d == '0) phase_d = PH_RECORD;
        end else begin
          write_hdr = 1'b1;
          bc_d      = bc_q + 5'd1;
          if (phase_q == PH_GLOBAL && bc_q == 5'd23) begin
            bc_d = '0;
            priority if ({hv[0], hv[1], hv[2], hv[3]} == 32'hd4c3b2a1) begin
              lem = 1'b1; nanom = 1'b0;
            end else if ({hv[0], hv[1], hv[2], hv[3]} == 32'ha1b2c3d4) begin
              lem = 1'b0; nanom = 1'b0;
            end else if ({hv[0], hv[1], hv[2], hv[3]} == 32'h4d3cb2a1) begin
              lem = 1'b1; nanom = 1'b1;
            end else if ({hv[0], hv[1], hv[2], hv[3]} == 32'ha1b23c4d) begin
              lem = 1'b0; nanom = 1'b1;
            end else begin
              okm = 1'b0;
            end
            v4    = lem ? {hv[5], hv[4]} : {hv[4], hv[5]};
            v6    = lem ? {hv[7], hv[6]} : {hv[6], hv[7]};
            snapw = word32(hv[16], hv[17], hv[18], hv[19], lem);
            item.kind = KIND_ERROR;
            priority if (!okm) begin
              push_o = 1'b1; item.code = ERR_MAGIC; phase_d = PH_HALTED;
            end else if (v4 != 16'd2 || v6 != 16'd4) begin
              push_o = 1'b1; item.code = ERR_VERSION; phase_d = PH_HALTED;
            end else if (snapw == '0) begin
              push_o = 1'b1; item.code = ERR_SNAPLEN; phase_d = PH_HALTED;
            end else begin
              snap_d  = snapw;
              link_d  = word32(hv[20], hv[21], hv[22], hv[23], lem);
              phase_d = PH_RECORD;
            end
            le_d   = lem;
            nano_d = nanom;
          end else if (phase_q == PH_RECORD && bc_q == 5'd15) begin
            bc_d        = '0;
            push_o      = 1'b1;
            item.kind   = KIND_HEADER;
            item.secs   = word32(hv[0], hv[1], hv[2], hv[3], le_q);
            item.frac   = word32(hv[4], hv[5], hv[6], hv[7], le_q);
            item.cap    = word32(hv[8], hv[9], hv[10], hv[11], le_q);
            item.orig   = word32(hv[12], hv[13], hv[14], hv[15], le_q);
            item.offset = pos_q - 64'd15;
            if (item.cap != '0) begin
              rem_d   = item.cap;
              phase_d = PH_PAYLOAD;
            end
          end
        end
      end
    end
  end

  assign push_data_o = item;

  always_ff @(posedge clk_i) begin
    if (write_hdr) hdr_q[bc_q] <= data_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GLOBAL;
      bc_q    <= '0;
      le_q    <= 1'b0;
      nano_q  <= 1'b0;
      snap_q  <= '0;
      link_q  <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      le_q    <= le_d;
      nano_q  <= nano_d;
      snap_q  <= snap_d;
      link_q  <= link_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/pcapp_back.sv
// pcapp_back: record checks, timestamp scaling and the output register.
// Depends on pcapp_pkg; drains pcapp_fifo.
`default_nettype none
module pcapp_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [31:0]          cfg_wdata_i,
  input  pcapp_pkg::hdr_info_t info_i,
  input  wire                  nonempty_i,
  input  pcapp_pkg::q_item_t   head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [1:0]           kind_o,
  output logic [63:0]          timestamp_ns_o,
  output logic [31:0]          link_type_o,
  output logic [31:0]          captured_length_o,
  output logic [31:0]          original_length_o,
  output logic [63:0]          record_offset_o,
  output logic [7:0]           payload_byte_o,
  output logic                 last_of_record_o,
  output logic [3:0]           error_code_o
);
  import pcapp_pkg::*;

  logic [31:0] max_cap_q;
  logic        s1_valid_q, out_valid_q, halted_q;
  q_item_t     s1_q;
  logic [61:0] secs_ns_q;
  logic [41:0] scaled_q;
  logic        frac_bad_q, snap_bad_q, lim_bad_q, orig_bad_q;
  logic        advance;
  logic [64:0] sum;
  kind_e       fin_kind;
  logic [3:0]  fin_code;
  logic        emit;

  logic [1:0]  kind_q;
  logic [63:0] ts_q, off_q;
  logic [31:0] link_q, cap_q, orig_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [3:0]  code_q;

  assign advance = !out_valid_q || out_ready_i;
  assign pop_o   = nonempty_i && (!s1_valid_q || advance);
  assign sum     = 65'(secs_ns_q) + 65'(scaled_q);
  assign emit    = s1_valid_q && !halted_q;

  always_comb begin
    fin_kind = s1_q.kind;
    fin_code = s1_q.code;
    if (s1_q.kind == KIND_HEADER) begin
      fin_kind = KIND_ERROR;
      priority if (frac_bad_q) fin_code = ERR_FRACTION;
      else if (sum[64])        fin_code = ERR_OVERFLOW;
      else if (snap_bad_q)     fin_code = ERR_OVER_SNAP;
      else if (lim_bad_q)      fin_code = ERR_OVER_LIMIT;
      else if (orig_bad_q)     fin_code = ERR_ORIG_SHORT;
      else begin
        fin_kind = KIND_HEADER;
        fin_code = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q       <= head_i;
      secs_ns_q  <= 62'(head_i.secs) * 62'(NS_PER_S);
      scaled_q   <= info_i.nano ? 42'(head_i.frac) : 42'(head_i.frac) * 42'(NS_PER_US);
      frac_bad_q <= head_i.frac >= (info_i.nano ? NS_PER_S : US_PER_S);
      snap_bad_q <= head_i.cap > info_i.snap;
      lim_bad_q  <= head_i.cap > max_cap_q;
      orig_bad_q <= head_i.orig < head_i.cap;
    end
    if (advance && emit) begin
      kind_q <= fin_kind;
      code_q <= (fin_kind == KIND_ERROR) ? fin_code : 4'd0;
      unique case (fin_kind)
        KIND_HEADER: begin
          ts_q   <= sum[63:0];
          link_q <= info_i.link;
          cap_q  <= s1_q.cap;
          orig_q <= s1_q.orig;
          off_q  <= s1_q.offset;
          byte_q <= '0;
          last_q <= (s1_q.cap == '0);
        end
        KIND_PAYLOAD: begin
          ts_q   <= '0; link_q <= '0; cap_q <= '0; orig_q <= '0; off_q <= '0;
          byte_q <= s1_q.data;
          last_q <= s1_q.last;
        end
        default: begin
          ts_q   <= '0; link_q <= '0; cap_q <= '0; orig_q <= '0; off_q <= '0;
          byte_q <= '0;
          last_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cap_q   <= MAX_CAP_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      halted_q    <= 1'b0;
    end else begin
      if (cfg_we_i) max_cap_q <= cfg_wdata_i;
      if (pop_o) s1_valid_q <= 1'b1;
      else if (advance) s1_valid_q <= 1'b0;
      if (advance) begin
        out_valid_q <= emit;
        if (emit && (fin_kind == KIND_ERROR || fin_kind == KIND_END)) halted_q <= 1'b1;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign timestamp_ns_o    = ts_q;
  assign link_type_o       = link_q;
  assign captured_length_o = cap_q;
  assign original_length_o = orig_q;
  assign record_offset_o   = off_q;
  assign payload_byte_o    = byte_q;
  assign last_of_record_o  = last_q;
  assign error_code_o      = code_q;
endmodule
`default_nettype wire

FILE: rtl/core/pcap_stream_parser.sv
// pcap_stream_parser: top level of the streaming pcap file parser.
// Depends on pcapp_pkg, pcapp_front, pcapp_fifo and pcapp_back.
`default_nettype none
// One file byte (or the end marker) is taken per cycle while the queue has
// room. The front collects header bytes and posts one request per result
// into a short queue; the back registers the checks of each record header
// and its scaled timestamp parts (the 32x30 seconds product among them) and
// holds the result in an output register, so throughput is one item a cycle
// while the output side keeps up. The first error or the end result halts
// the block; later items are taken and dropped.
module pcap_stream_parser #(
  parameter int unsigned QueueDepth = pcapp_pkg::QUEUE_DEPTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [31:0] cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  data_byte_i,
  input  wire         end_of_input_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  kind_o,
  output logic [63:0] timestamp_ns_o,
  output logic [31:0] link_type_o,
  output logic [31:0] captured_length_o,
  output logic [31:0] original_length_o,
  output logic [63:0] record_offset_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_record_o,
  output logic [3:0]  error_code_o
);
  import pcapp_pkg::*;

  logic      push, full, pop, nonempty;
  q_item_t   push_data, head;
  hdr_info_t info;

  pcapp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i, .end_of_input_i,
    .full_i(full), .push_o(push), .push_data_o(push_data), .info_o(info)
  );

  pcapp_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .nonempty_o(nonempty), .head_o(head)
  );

  pcapp_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .info_i(info),
    .nonempty_i(nonempty), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_ready_i, .kind_o, .timestamp_ns_o, .link_type_o,
    .captured_length_o, .original_length_o, .record_offset_o,
    .payload_byte_o, .last_of_record_o, .error_code_o
  );

  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_ERROR |-> error_code_o == 4'd0)
    else $error("error code set on non-error result");

  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (kind_o == KIND_ERROR || kind_o == KIND_END)
    |=> !out_valid_o)
    else $error("result after halt");

  a_last_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_HEADER |-> last_of_record_o == (captured_length_o == '0))
    else $error("header last mark mismatch");
endmodule
`default_nettype wire
